/* sv/nand_command_sequencer_top_assert.svh */
// Assertion macros for the NAND command sequencer checker.
// Clocked on clock, disabled while reset is high; no other dependencies.
`ifndef NAND_COMMAND_SEQUENCER_TOP_ASSERT_SVH
`define NAND_COMMAND_SEQUENCER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define NCS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define NCS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/ncs_pkg.sv */
// Shared types, widths and bus constants of the NAND command sequencer.
// No dependencies; imported by all other files but the assertion header.
package ncs_pkg;

   // Field widths
   localparam int CMD_W      = 3;
   localparam int OFF_W      = 27;
   localparam int LEN_W      = 27;
   localparam int BYTE_W     = 8;
   localparam int SKIP_W     = 5;
   localparam int LOG_W      = 4;
   localparam int PPB_W      = 7;
   localparam int NBLK_W     = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   // Address arithmetic
   localparam int PAGE_W      = 19;   // page number of any offset
   localparam int COL_W       = 10;   // column within a page, spare included
   localparam int LIM_W       = 19;   // pages in the device, up to 2^18
   localparam int RECIP_W     = 26;   // ceil(2^25 / pages_per_block)
   localparam int RECIP_SHIFT = 25;
   localparam int DIV_A_W     = 24;   // offset with the low 3 or 4 bits removed
   localparam int DIV33_W     = 25;
   localparam int DIV33_SHIFT = 30;
   localparam logic [DIV33_W-1:0] DIV33_MULT = 25'd32537631; // (2^30-1)/33

   // Results per item
   localparam int IDX_W = 3;

   // Status byte bits
   localparam int STATUS_READY_BIT = 6;
   localparam int STATUS_FAIL_BIT  = 0;

   // Flash bus command bytes
   localparam logic [BYTE_W-1:0] BUS_READ_MAIN     = 8'h00;
   localparam logic [BYTE_W-1:0] BUS_READ_HALF2    = 8'h01;
   localparam logic [BYTE_W-1:0] BUS_PROG_CONFIRM  = 8'h10;
   localparam logic [BYTE_W-1:0] BUS_READ_SPARE    = 8'h50;
   localparam logic [BYTE_W-1:0] BUS_ERASE_SETUP   = 8'h60;
   localparam logic [BYTE_W-1:0] BUS_READ_STATUS   = 8'h70;
   localparam logic [BYTE_W-1:0] BUS_PROG_SETUP    = 8'h80;
   localparam logic [BYTE_W-1:0] BUS_ERASE_CONFIRM = 8'hd0;

   typedef enum logic [CMD_W-1:0] {
      CMD_ERASE      = 3'd0,
      CMD_PROG_BEGIN = 3'd1,
      CMD_PROG_DATA  = 3'd2,
      CMD_PROG_END   = 3'd3,
      CMD_READ_BEGIN = 3'd4,
      CMD_STATUS     = 3'd5
   } ncs_cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PAGE_LOG2       = 2'd0,
      REG_PAGES_PER_BLOCK = 2'd1,
      REG_BLOCK_COUNT     = 2'd2
   } ncs_reg_type;

   // What an item turns into once its address is decoded
   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_ERASE,
      KIND_REJECT,
      KIND_PROG_BEGIN,
      KIND_DATA,
      KIND_PROG_END,
      KIND_READ,
      KIND_STATUS
   } ncs_kind_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [OFF_W-1:0]  byte_offset;
      logic [LEN_W-1:0]  length;
      logic [BYTE_W-1:0] data_byte;
   } ncs_req_type;

   typedef struct packed {
      logic               big_page;  // 512 main bytes per page
      logic [PPB_W-1:0]   ppb;       // saturated pages per block
      logic [RECIP_W-1:0] recip;     // reciprocal of ppb
      logic [LIM_W-1:0]   lim;       // pages in the device
      logic               busy;      // reciprocal being recomputed
   } ncs_cfg_type;

   typedef struct packed {
      ncs_kind_type      kind;
      logic [BYTE_W-1:0] ptr;
      logic [BYTE_W-1:0] col_byte;
      logic [BYTE_W-1:0] page_lo;
      logic [BYTE_W-1:0] page_hi;
      logic [BYTE_W-1:0] data_byte;
      logic [SKIP_W-1:0] skip;
   } ncs_item_type;

   typedef struct packed {
      logic              cle;
      logic              ale;
      logic [BYTE_W-1:0] bus_byte;
      logic              bus_cycle;
      logic              done_res;
      logic              fail;
      logic [SKIP_W-1:0] skip_count;
      logic              last;
   } ncs_result_type;

endpackage

/* sv/ncs_if.sv */
// Channel interfaces of the NAND command sequencer: request, result, register write.
// Depends on ncs_pkg for field widths.
interface ncs_req_if import ncs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [OFF_W-1:0]  byte_offset;
   logic [LEN_W-1:0]  length;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, cmd, byte_offset, length, data_byte, input ready);
   modport sink   (input valid, cmd, byte_offset, length, data_byte, output ready);
endinterface

interface ncs_rsp_if import ncs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              cle;
   logic              ale;
   logic [BYTE_W-1:0] bus_byte;
   logic              bus_cycle;
   logic              done_res;
   logic              fail;
   logic [SKIP_W-1:0] skip_count;
   logic              last;

   modport source (output valid, cle, ale, bus_byte, bus_cycle, done_res, fail,
                   skip_count, last, input ready);
   modport sink   (input valid, cle, ale, bus_byte, bus_cycle, done_res, fail,
                   skip_count, last, output ready);
endinterface

interface ncs_csr_if import ncs_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

/* sv/nand_command_sequencer_top.sv */
// Top level of the small-page NAND command sequencer.
// Depends on ncs_pkg, ncs_if, ncs_cfg, ncs_addr and ncs_expand.
//
// Usage:
//  - req_chan carries flash requests (erase, program begin/data/end, read
//    begin, status byte). A transfer happens when valid and ready are high.
//  - rsp_chan returns one result per transfer: a flash bus cycle (CLE or ALE
//    for command and address) or a status result; last marks an item's end.
//  - csr_chan writes page_size_log2, pages_per_block and block_count by index.
//  - The first result of an item passes the four address stages, then the
//    expander's item register and its output register.
//  - Throughput: one item per cycle while each makes one result (data and
//    status bytes); an item with more results holds the input until its last.
//  - The pipeline carries valid bits; when rsp_chan stalls, the expander
//    holds its item and the stages and req_chan.ready stop with it.
//  - After reset, and after each pages_per_block write, req_chan.ready stays
//    low while the pages-per-block reciprocal is rebuilt one quotient bit per
//    cycle.
module nand_command_sequencer_top import ncs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ncs_req_if.sink   req_chan,
   ncs_rsp_if.source rsp_chan,
   ncs_csr_if.sink   csr_chan
);

   ncs_cfg_type    cfg;
   ncs_req_type    req;
   ncs_item_type   item;
   ncs_result_type res;
   logic           adv, item_valid, res_valid, req_take;

   // Register file and reciprocal unit
   ncs_cfg u_cfg (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // Input side
   always_comb begin
      req.cmd         = req_chan.cmd;
      req.byte_offset = req_chan.byte_offset;
      req.length      = req_chan.length;
      req.data_byte   = req_chan.data_byte;
   end

   assign req_chan.ready = adv && !cfg.busy;
   assign req_take       = req_chan.valid && req_chan.ready;

   // Address pipeline
   ncs_addr u_addr (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_take),
      .in_req    (req),
      .cfg       (cfg),
      .out_valid (item_valid),
      .out_item  (item)
   );

   // Result expansion and output register
   ncs_expand u_expand (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (item_valid),
      .in_item   (item),
      .out_ready (rsp_chan.ready),
      .adv       (adv),
      .out_valid (res_valid),
      .out_res   (res)
   );

   // Output side
   always_comb begin
      rsp_chan.valid      = res_valid;
      rsp_chan.cle        = res.cle;
      rsp_chan.ale        = res.ale;
      rsp_chan.bus_byte   = res.bus_byte;
      rsp_chan.bus_cycle  = res.bus_cycle;
      rsp_chan.done_res   = res.done_res;
      rsp_chan.fail       = res.fail;
      rsp_chan.skip_count = res.skip_count;
      rsp_chan.last       = res.last;
   end

endmodule

/* sv/ncs_cfg.sv */
// Configuration registers with saturation, device page limit and the
// pages-per-block reciprocal unit. Depends on ncs_pkg and ncs_csr_if.
module ncs_cfg import ncs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ncs_csr_if.sink     csr_chan,
   output ncs_cfg_type cfg
);

   localparam logic [PPB_W-1:0]  PPB_MAX     = 7'd64;
   localparam logic [NBLK_W-1:0] NBLK_MAX    = 13'd4096;
   localparam logic [LOG_W-1:0]  LOG_BIG     = 4'd9;
   localparam logic [4:0]        RECIP_LAST  = 5'(RECIP_SHIFT - 1);

   logic [LOG_W-1:0]        log_ff, log_in;
   logic [PPB_W-1:0]        ppb_raw_ff, ppb_raw_in;
   logic [NBLK_W-1:0]       nblk_raw_ff, nblk_raw_in;
   logic [PPB_W-1:0]        ppb_sat;
   logic [NBLK_W-1:0]       nblk_sat;
   logic [PPB_W+NBLK_W-1:0] lim_prod;
   logic [LIM_W-1:0]        lim_ff, lim_in;
   logic                    busy_ff, busy_in;
   logic [4:0]              step_ff, step_in;
   logic [PPB_W-1:0]        rem_ff, rem_in;
   logic [RECIP_SHIFT-1:0]  quo_ff, quo_in;
   logic [RECIP_W-1:0]      recip_ff, recip_in;
   logic [PPB_W:0]          rem_sh;
   logic                    ppb_write;

   assign csr_chan.ready = 1'b1;

   // Register writes
   always_comb begin
      log_in      = log_ff;
      ppb_raw_in  = ppb_raw_ff;
      nblk_raw_in = nblk_raw_ff;
      ppb_write   = 1'b0;
      if (csr_chan.valid) begin
         case (ncs_reg_type'(csr_chan.reg_index))
            REG_PAGE_LOG2:       log_in = csr_chan.wdata[LOG_W-1:0];
            REG_PAGES_PER_BLOCK: begin
               ppb_raw_in = csr_chan.wdata[PPB_W-1:0];
               ppb_write  = 1'b1;
            end
            REG_BLOCK_COUNT:     nblk_raw_in = csr_chan.wdata[NBLK_W-1:0];
            default:             ;
         endcase
      end
   end

   // Saturate to the legal ranges
   always_comb begin
      if (ppb_raw_ff == '0) begin
         ppb_sat = PPB_W'(1);
      end else if (ppb_raw_ff > PPB_MAX) begin
         ppb_sat = PPB_MAX;
      end else begin
         ppb_sat = ppb_raw_ff;
      end
      if (nblk_raw_ff == '0) begin
         nblk_sat = NBLK_W'(1);
      end else if (nblk_raw_ff > NBLK_MAX) begin
         nblk_sat = NBLK_MAX;
      end else begin
         nblk_sat = nblk_raw_ff;
      end
   end

   // Device size in pages, updated in the cycle after the registers
   assign lim_prod = {{NBLK_W{1'b0}}, ppb_sat} * {{PPB_W{1'b0}}, nblk_sat};
   assign lim_in   = lim_prod[LIM_W-1:0];

   // Restoring division of 2^25-1 by ppb, one quotient bit per cycle;
   // the reciprocal is that quotient plus one.
   always_comb begin
      busy_in  = busy_ff;
      step_in  = step_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      recip_in = recip_ff;
      rem_sh   = {rem_ff, 1'b1};
      if (ppb_write) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, ppb_sat}) begin
            rem_sh = rem_sh - {1'b0, ppb_sat};
            quo_in = {quo_ff[RECIP_SHIFT-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[RECIP_SHIFT-2:0], 1'b0};
         end
         rem_in  = rem_sh[PPB_W-1:0];
         step_in = step_ff + 5'd1;
         if (step_ff == RECIP_LAST) begin
            busy_in  = 1'b0;
            recip_in = {1'b0, quo_in} + RECIP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         log_ff      <= LOG_BIG;
         ppb_raw_ff  <= 7'd16;
         nblk_raw_ff <= 13'd1024;
         busy_ff     <= 1'b1;
         step_ff     <= '0;
         rem_ff      <= '0;
         quo_ff      <= '0;
      end else begin
         log_ff      <= log_in;
         ppb_raw_ff  <= ppb_raw_in;
         nblk_raw_ff <= nblk_raw_in;
         busy_ff     <= busy_in;
         step_ff     <= step_in;
         rem_ff      <= rem_in;
         quo_ff      <= quo_in;
      end
   end

   always_ff @(posedge clock) begin
      lim_ff   <= lim_in;
      recip_ff <= recip_in;
   end

   always_comb begin
      cfg.big_page = (log_ff >= LOG_BIG);
      cfg.ppb      = ppb_sat;
      cfg.recip    = recip_ff;
      cfg.lim      = lim_ff;
      cfg.busy     = busy_ff;
   end

endmodule

/* sv/ncs_addr.sv */
// Four-stage address pipeline: page and column split, pointer and read
// back-up, erase alignment and range check, then item decode.
// Depends on ncs_pkg.
module ncs_addr import ncs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         adv,
   input  logic         in_valid,
   input  ncs_req_type  in_req,
   input  ncs_cfg_type  cfg,
   output logic         out_valid,
   output ncs_item_type out_item
);

   localparam int PROD_W  = DIV_A_W + DIV33_W;
   localparam int DPROD_W = PAGE_W + RECIP_W;
   localparam int CHK_W   = PAGE_W + PPB_W;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [LEN_W-1:0]  length;
      logic [BYTE_W-1:0] data_byte;
   } pass_type;

   // stage 1: captured request
   logic        v1_ff;
   ncs_req_type r1_ff;

   // stage 2: quotient estimate by 33
   logic               v2_ff;
   pass_type           p2_ff, p1;
   logic [PAGE_W-1:0]  q0_2_ff;
   logic [DIV_A_W-1:0] a2_ff;
   logic [3:0]         lo2_ff;
   logic [DIV_A_W-1:0] a1;
   logic [PROD_W-1:0]  prod1;

   // stage 3: page and column
   logic               v3_ff;
   pass_type           p3_ff;
   logic [PAGE_W-1:0]  page3_ff, page2;
   logic [COL_W-1:0]   col3_ff, col2;
   logic [DIV_A_W-1:0] q33, r0;
   logic [6:0]         r0n, rfix;
   logic               fix2;

   // stage 4: pointer, read back-up, erase pre-checks
   logic               v4_ff;
   pass_type           p4_ff;
   logic [PAGE_W-1:0]  qd4_ff, page4_ff;
   logic [BYTE_W-1:0]  ptr4_ff, colb4_ff, ptr3;
   logic [SKIP_W-1:0]  skip4_ff, skip3;
   logic               epre4_ff, epre3;
   logic [DPROD_W-1:0] dprod3;
   logic [COL_W-1:0]   bpp, xbpp, room, colr, sk10;
   logic               back;

   // stage 5 decode
   logic [CHK_W-1:0]   chk;
   logic               erase_ok;

   // Stage 2 input: offset over 8 or 16, times the reciprocal of 33
   always_comb begin
      p1.cmd       = r1_ff.cmd;
      p1.length    = r1_ff.length;
      p1.data_byte = r1_ff.data_byte;
      if (cfg.big_page) begin
         a1 = {1'b0, r1_ff.byte_offset[OFF_W-1:4]};
      end else begin
         a1 = r1_ff.byte_offset[OFF_W-1:3];
      end
      prod1 = a1 * DIV33_MULT;
   end

   // Stage 3 input: correct the estimate, rebuild the column
   always_comb begin
      q33  = {q0_2_ff, 5'b0} + {5'b0, q0_2_ff};
      r0   = a2_ff - q33;
      r0n  = r0[6:0];
      fix2 = (r0n >= 7'd33);
      page2 = q0_2_ff + PAGE_W'(fix2);
      rfix  = fix2 ? (r0n - 7'd33) : r0n;
      if (cfg.big_page) begin
         col2 = {rfix[5:0], lo2_ff};
      end else begin
         col2 = {1'b0, rfix[5:0], lo2_ff[2:0]};
      end
   end

   // Stage 4 input: page over ppb, pointer, read back-up and erase pre-check
   always_comb begin
      dprod3 = {{RECIP_W{1'b0}}, page3_ff} * {{PAGE_W{1'b0}}, cfg.recip};
      bpp    = cfg.big_page ? 10'd512 : 10'd256;
      xbpp   = cfg.big_page ? 10'd528 : 10'd264;
      room   = xbpp - col3_ff;
      back   = (ncs_cmd_type'(p3_ff.cmd) == CMD_READ_BEGIN) && (col3_ff >= bpp) &&
               ({{(LEN_W-COL_W){1'b0}}, room} < p3_ff.length);
      sk10   = col3_ff - bpp + 10'd1;
      skip3  = back ? sk10[SKIP_W-1:0] : '0;
      colr   = back ? (bpp - 10'd1) : col3_ff;
      if (colr >= bpp) begin
         ptr3 = BUS_READ_SPARE;
      end else if (colr >= 10'd256) begin
         ptr3 = BUS_READ_HALF2;
      end else begin
         ptr3 = BUS_READ_MAIN;
      end
      epre3 = (col3_ff == '0) && (page3_ff < cfg.lim);
   end

   // Pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r1_ff    <= in_req;
         p2_ff    <= p1;
         q0_2_ff  <= prod1[DIV33_SHIFT+PAGE_W-1:DIV33_SHIFT];
         a2_ff    <= a1;
         lo2_ff   <= r1_ff.byte_offset[3:0];
         p3_ff    <= p2_ff;
         page3_ff <= page2;
         col3_ff  <= col2;
         p4_ff    <= p3_ff;
         qd4_ff   <= dprod3[RECIP_SHIFT+PAGE_W-1:RECIP_SHIFT];
         page4_ff <= page3_ff;
         ptr4_ff  <= ptr3;
         colb4_ff <= colr[BYTE_W-1:0];
         skip4_ff <= skip3;
         epre4_ff <= epre3;
      end
   end

   // Stage 5: block alignment and item decode
   always_comb begin
      chk      = {{PPB_W{1'b0}}, qd4_ff} * {{PAGE_W{1'b0}}, cfg.ppb};
      erase_ok = epre4_ff && (chk == {{PPB_W{1'b0}}, page4_ff});
      out_valid          = v4_ff;
      out_item.ptr       = ptr4_ff;
      out_item.col_byte  = colb4_ff;
      out_item.page_lo   = page4_ff[BYTE_W-1:0];
      out_item.page_hi   = page4_ff[2*BYTE_W-1:BYTE_W];
      out_item.data_byte = p4_ff.data_byte;
      out_item.skip      = skip4_ff;
      case (ncs_cmd_type'(p4_ff.cmd))
         CMD_ERASE:      out_item.kind = erase_ok ? KIND_ERASE : KIND_REJECT;
         CMD_PROG_BEGIN: out_item.kind = KIND_PROG_BEGIN;
         CMD_PROG_DATA:  out_item.kind = KIND_DATA;
         CMD_PROG_END:   out_item.kind = KIND_PROG_END;
         CMD_READ_BEGIN: out_item.kind = KIND_READ;
         CMD_STATUS:     out_item.kind = KIND_STATUS;
         default:        out_item.kind = KIND_NONE;
      endcase
   end

endmodule

/* sv/ncs_expand.sv */
// Result expander: holds one decoded item, emits its results one per cycle
// into the output register while it has room. Depends on ncs_pkg.
module ncs_expand import ncs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  ncs_item_type   in_item,
   input  logic           out_ready,
   output logic           adv,
   output logic           out_valid,
   output ncs_result_type out_res
);

   function automatic logic [IDX_W-1:0] result_count(input ncs_kind_type kind);
      logic [IDX_W-1:0] n;
      case (kind)
         KIND_ERASE:      n = 3'd5;
         KIND_PROG_BEGIN: n = 3'd5;
         KIND_READ:       n = 3'd4;
         KIND_PROG_END:   n = 3'd2;
         KIND_REJECT:     n = 3'd1;
         KIND_DATA:       n = 3'd1;
         KIND_STATUS:     n = 3'd1;
         default:         n = 3'd0;
      endcase
      return n;
   endfunction

   // Result number idx of an item
   function automatic ncs_result_type gen_result(input ncs_item_type it,
                                                 input logic [IDX_W-1:0] idx);
      ncs_result_type r;
      r           = '0;
      r.bus_cycle = 1'b1;
      case (it.kind)
         KIND_ERASE: begin
            case (idx)
               3'd0:    begin r.cle = 1'b1; r.bus_byte = BUS_ERASE_SETUP; end
               3'd1:    begin r.ale = 1'b1; r.bus_byte = it.page_lo; end
               3'd2:    begin r.ale = 1'b1; r.bus_byte = it.page_hi; end
               3'd3:    begin r.cle = 1'b1; r.bus_byte = BUS_ERASE_CONFIRM; end
               default: begin r.cle = 1'b1; r.bus_byte = BUS_READ_STATUS; end
            endcase
         end
         KIND_PROG_BEGIN: begin
            case (idx)
               3'd0:    begin r.cle = 1'b1; r.bus_byte = it.ptr; end
               3'd1:    begin r.cle = 1'b1; r.bus_byte = BUS_PROG_SETUP; end
               3'd2:    begin r.ale = 1'b1; r.bus_byte = it.col_byte; end
               3'd3:    begin r.ale = 1'b1; r.bus_byte = it.page_lo; end
               default: begin r.ale = 1'b1; r.bus_byte = it.page_hi; end
            endcase
         end
         KIND_READ: begin
            r.skip_count = it.skip;
            case (idx)
               3'd0:    begin r.cle = 1'b1; r.bus_byte = it.ptr; end
               3'd1:    begin r.ale = 1'b1; r.bus_byte = it.col_byte; end
               3'd2:    begin r.ale = 1'b1; r.bus_byte = it.page_lo; end
               default: begin r.ale = 1'b1; r.bus_byte = it.page_hi; end
            endcase
         end
         KIND_PROG_END: begin
            r.cle      = 1'b1;
            r.bus_byte = (idx == '0) ? BUS_PROG_CONFIRM : BUS_READ_STATUS;
         end
         KIND_DATA: r.bus_byte = it.data_byte;
         KIND_REJECT: begin
            r.bus_cycle = 1'b0;
            r.done_res  = 1'b1;
            r.fail      = 1'b1;
         end
         KIND_STATUS: begin
            r.bus_cycle = 1'b0;
            r.done_res  = it.data_byte[STATUS_READY_BIT];
            r.fail      = it.data_byte[STATUS_READY_BIT] & it.data_byte[STATUS_FAIL_BIT];
         end
         default: r.bus_cycle = 1'b0;
      endcase
      r.last = (idx == result_count(it.kind) - 3'd1);
      return r;
   endfunction

   logic             e_valid_ff, e_valid_in;
   ncs_item_type     e_item_ff, e_item_in;
   logic [IDX_W-1:0] e_idx_ff, e_idx_in;
   logic             o_valid_ff, o_valid_in;
   ncs_result_type   o_res_ff, o_res_in;
   logic             o_free, emit, e_last;

   // Emit control: the held item frees the pipeline on its final result
   always_comb begin
      e_last     = (e_idx_ff == result_count(e_item_ff.kind) - 3'd1);
      o_free     = !o_valid_ff || out_ready;
      emit       = e_valid_ff && o_free;
      adv        = !e_valid_ff || (emit && e_last);
      o_valid_in = emit ? 1'b1 : (out_ready ? 1'b0 : o_valid_ff);
      o_res_in   = emit ? gen_result(e_item_ff, e_idx_ff) : o_res_ff;
      e_valid_in = e_valid_ff;
      e_item_in  = e_item_ff;
      e_idx_in   = e_idx_ff;
      if (adv) begin
         e_valid_in = in_valid && (in_item.kind != KIND_NONE);
         e_item_in  = in_item;
         e_idx_in   = '0;
      end else if (emit) begin
         e_idx_in = e_idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         e_idx_ff   <= '0;
         o_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= e_valid_in;
         e_idx_ff   <= e_idx_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      e_item_ff <= e_item_in;
      o_res_ff  <= o_res_in;
   end

   assign out_valid = o_valid_ff;
   assign out_res   = o_res_ff;

endmodule

/* sv/ncs_checker.sv */
// Port-level checker of the NAND command sequencer, bound to the top level.
// Depends on ncs_pkg and nand_command_sequencer_top_assert.svh.
`include "nand_command_sequencer_top_assert.svh"

module ncs_checker import ncs_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_cle,
   input logic                 rsp_ale,
   input logic [BYTE_W-1:0]    rsp_bus_byte,
   input logic                 rsp_bus_cycle,
   input logic                 rsp_done_res,
   input logic                 rsp_fail,
   input logic [SKIP_W-1:0]    rsp_skip_count,
   input logic                 rsp_last,
   input logic                 csr_valid,
   input logic                 csr_ready,
   input logic [CSR_IDX_W-1:0] csr_reg_index
);

   // A stalled result holds
   `NCS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_bus_byte) && $stable(rsp_cle) && $stable(rsp_ale) && $stable(rsp_bus_cycle) && $stable(rsp_done_res) && $stable(rsp_fail) && $stable(rsp_skip_count) && $stable(rsp_last), "stalled result changed")

   // Results of one item come back to back
   `NCS_ASSERT_NEXT(a_burst_cont, rsp_valid && rsp_ready && !rsp_last, rsp_valid, "gap inside a multi-result item")

   // Status and reject results stand alone and drive nothing on the bus
   `NCS_ASSERT_NOW(a_nobus_alone, rsp_valid && !rsp_bus_cycle, rsp_last && (rsp_bus_byte == 8'h00) && !rsp_cle && !rsp_ale, "non-bus result malformed")

   // A pages_per_block write blocks requests while the reciprocal rebuilds
   `NCS_ASSERT_NEXT(a_ppb_busy, csr_valid && csr_ready && (csr_reg_index == REG_PAGES_PER_BLOCK), !req_ready, "request taken during reciprocal rebuild")

endmodule

bind nand_command_sequencer_top ncs_checker u_ncs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_cle        (rsp_chan.cle),
   .rsp_ale        (rsp_chan.ale),
   .rsp_bus_byte   (rsp_chan.bus_byte),
   .rsp_bus_cycle  (rsp_chan.bus_cycle),
   .rsp_done_res   (rsp_chan.done_res),
   .rsp_fail       (rsp_chan.fail),
   .rsp_skip_count (rsp_chan.skip_count),
   .rsp_last       (rsp_chan.last),
   .csr_valid      (csr_chan.valid),
   .csr_ready      (csr_chan.ready),
   .csr_reg_index  (csr_chan.reg_index)
);

/* test/ncs_bus_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the NAND command sequencer: watches the request, result and
// register-write channels, predicts every bus cycle and compares in order.
// Depends on ncs_pkg and the channel interfaces of ncs_if.
module ncs_bus_checker import ncs_pkg::*; (
   input  logic clock,
   input  logic reset,
   ncs_req_if   req_chan,
   ncs_rsp_if   rsp_chan,
   ncs_csr_if   csr_chan,
   output int   mismatch_total,
   output int   outstanding
);
   localparam int REPORT_LIMIT = 10;
   localparam longint unsigned HALF_PAGE = 256;

   // Local copy of the geometry registers, raw as written
   logic [LOG_W-1:0]  page_log2;
   logic [PPB_W-1:0]  blk_pages;
   logic [NBLK_W-1:0] dev_blocks;

   ncs_result_type expected_cycles[$];
   int             mismatches = 0;

   function automatic void add_cycle(input logic cle, ale, input logic [BYTE_W-1:0] bus_byte,
                                     input logic bus, done, fail,
                                     input logic [SKIP_W-1:0] skip);
      ncs_result_type c;
      c = {cle, ale, bus_byte, bus, done, fail, skip, 1'b0};
      expected_cycles.push_back(c);
   endfunction

   function automatic string describe(input ncs_result_type c);
      return $sformatf("cle=%0b ale=%0b byte=%02h bus=%0b done=%0b fail=%0b skip=%0d last=%0b",
                       c.cle, c.ale, c.bus_byte, c.bus_cycle, c.done_res, c.fail,
                       c.skip_count, c.last);
   endfunction

   // Bus cycles that one request turns into under the current geometry
   function automatic void plan_bus_cycles(input ncs_req_type r);
      longint unsigned main_sz, page_sz, ppb, nblk, blk_sz, off, page, col, skip;
      logic [BYTE_W-1:0] ptr;
      ncs_result_type    tail;
      int                depth;
      depth   = expected_cycles.size();
      main_sz = 1 << ((page_log2 < 8) ? 8 : ((page_log2 > 9) ? 9 : page_log2));
      page_sz = main_sz + main_sz / 32;
      ppb     = (blk_pages == 0) ? 1 : ((blk_pages > 64) ? 64 : blk_pages);
      nblk    = (dev_blocks == 0) ? 1 : ((dev_blocks > 4096) ? 4096 : dev_blocks);
      off     = r.byte_offset;
      case (r.cmd)
         CMD_ERASE: begin
            blk_sz = page_sz * ppb;
            if (off % blk_sz != 0 || off >= blk_sz * nblk) begin
               // rejected: a bare status result, no bus traffic
               add_cycle(0, 0, 8'h00, 0, 1, 1, 0);
            end else begin
               page = off / blk_sz * ppb;
               add_cycle(1, 0, BUS_ERASE_SETUP, 1, 0, 0, 0);
               add_cycle(0, 1, BYTE_W'(page), 1, 0, 0, 0);
               add_cycle(0, 1, BYTE_W'(page >> 8), 1, 0, 0, 0);
               add_cycle(1, 0, BUS_ERASE_CONFIRM, 1, 0, 0, 0);
               add_cycle(1, 0, BUS_READ_STATUS, 1, 0, 0, 0);
            end
         end
         CMD_PROG_BEGIN, CMD_READ_BEGIN: begin
            page = off / page_sz;
            col  = off % page_sz;
            skip = 0;
            // a read from the spare area that runs past the page end
            // restarts at the last main byte; the caller drops the extra bytes
            if (r.cmd == CMD_READ_BEGIN && col >= main_sz && page_sz - col < r.length) begin
               skip = col - main_sz + 1;
               col  = main_sz - 1;
            end
            // pointer command selects the area, column is relative to it
            if (col >= main_sz) begin
               col -= main_sz;
               ptr  = BUS_READ_SPARE;
            end else if (col >= HALF_PAGE) begin
               col -= HALF_PAGE;
               ptr  = BUS_READ_HALF2;
            end else begin
               ptr = BUS_READ_MAIN;
            end
            add_cycle(1, 0, ptr, 1, 0, 0, SKIP_W'(skip));
            if (r.cmd == CMD_PROG_BEGIN)
               add_cycle(1, 0, BUS_PROG_SETUP, 1, 0, 0, 0);
            add_cycle(0, 1, BYTE_W'(col), 1, 0, 0, SKIP_W'(skip));
            add_cycle(0, 1, BYTE_W'(page), 1, 0, 0, SKIP_W'(skip));
            add_cycle(0, 1, BYTE_W'(page >> 8), 1, 0, 0, SKIP_W'(skip));
         end
         CMD_PROG_DATA: add_cycle(0, 0, r.data_byte, 1, 0, 0, 0);
         CMD_PROG_END: begin
            add_cycle(1, 0, BUS_PROG_CONFIRM, 1, 0, 0, 0);
            add_cycle(1, 0, BUS_READ_STATUS, 1, 0, 0, 0);
         end
         CMD_STATUS: begin
            // fail only counts once the chip reports ready
            add_cycle(0, 0, 8'h00, 0, r.data_byte[STATUS_READY_BIT],
                      r.data_byte[STATUS_READY_BIT] & r.data_byte[STATUS_FAIL_BIT], 0);
         end
         default: ;  // unused codes produce nothing
      endcase
      if (expected_cycles.size() > depth) begin
         tail      = expected_cycles.pop_back();
         tail.last = 1'b1;
         expected_cycles.push_back(tail);
      end
   endfunction

   function automatic void note_failure(input string why);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("%0t: %s", $realtime, why);
   endfunction

   // Sample every channel at the clock edge
   always @(posedge clock) begin : watch
      ncs_result_type got;
      ncs_result_type want;
      if (reset) begin
         page_log2  = 4'd9;
         blk_pages  = 7'd16;
         dev_blocks = 13'd1024;
         expected_cycles.delete();
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            case (csr_chan.reg_index)
               REG_PAGE_LOG2:       page_log2  = csr_chan.wdata[LOG_W-1:0];
               REG_PAGES_PER_BLOCK: blk_pages  = csr_chan.wdata[PPB_W-1:0];
               REG_BLOCK_COUNT:     dev_blocks = csr_chan.wdata[NBLK_W-1:0];
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready)
            plan_bus_cycles({req_chan.cmd, req_chan.byte_offset, req_chan.length,
                             req_chan.data_byte});
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = {rsp_chan.cle, rsp_chan.ale, rsp_chan.bus_byte, rsp_chan.bus_cycle,
                   rsp_chan.done_res, rsp_chan.fail, rsp_chan.skip_count, rsp_chan.last};
            if (expected_cycles.size() == 0) begin
               note_failure({"unexpected result: ", describe(got)});
            end else begin
               want = expected_cycles.pop_front();
               if (got !== want)
                  note_failure({"result mismatch: expected ", describe(want),
                                " got ", describe(got)});
            end
         end
      end
      outstanding    <= expected_cycles.size();
      mismatch_total <= mismatches;
   end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top for the NAND command sequencer: clock, reset, request and
// register stimulus, result-side stalls and the verdict.
// Depends on ncs_pkg, ncs_if, nand_command_sequencer_top and ncs_bus_checker.
module tb_top;
   import ncs_pkg::*;

   localparam int RANDOM_PER_PHASE = 14;
   localparam int DRAIN_CYCLES     = 12;
   localparam int LONG_HOLD        = 200;
   localparam int SQUEEZE_ITEMS    = 20;
   localparam longint unsigned HALF_PAGE = 256;
   localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
   localparam logic [OFF_W-1:0] OFF_MAX = '1;
   localparam logic [LEN_W-1:0] LEN_MAX = '1;
   // geometry after reset: 512 + 16 bytes per page, 16 pages per block, 1024 blocks
   localparam int DEF_BLOCK_BYTES = 528 * 16;
   localparam int DEF_BLOCKS      = 1024;

   typedef enum {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_ALTERNATE} sink_mode_type;

   logic clock;
   logic reset;
   int   errors;
   int   pending;
   int   burst_left;
   int   hold_requests = 0;
   logic [CSR_DATA_W-1:0] geo_log2, geo_ppb, geo_blocks;

   ncs_req_if req_chan ();
   ncs_rsp_if rsp_chan ();
   ncs_csr_if csr_chan ();

   nand_command_sequencer_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   ncs_bus_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_chan       (csr_chan),
      .mismatch_total (errors),
      .outstanding    (pending)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial begin : watchdog
      #500000;
      $display("DONE: errors detected");
      $finish;
   end

   // Result side: stall patterns picked at random, plus a long hold-off whenever
   // the stimulus asks for one
   initial begin : result_sink
      sink_mode_type mode;
      int            mode_left;
      int            hold_left;
      int            holds_taken;
      mode        = SINK_OPEN;
      mode_left   = 0;
      hold_left   = 0;
      holds_taken = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (holds_taken != hold_requests) begin
            holds_taken = hold_requests;
            hold_left   = LONG_HOLD;
            rsp_chan.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = sink_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(8, 60);
            end
            mode_left--;
            case (mode)
               SINK_OPEN:   rsp_chan.ready <= 1'b1;
               SINK_COIN:   rsp_chan.ready <= 1'($urandom_range(0, 1));
               SINK_SPARSE: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
               default:     rsp_chan.ready <= ~rsp_chan.ready;
            endcase
         end
      end
   end

   // One request transfer; starts a new burst after a random gap when the last one ran out
   task automatic offer_request(input logic [CMD_W-1:0] cmd, input logic [OFF_W-1:0] off,
                                input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] db);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid       <= 1'b1;
      req_chan.cmd         <= cmd;
      req_chan.byte_offset <= off;
      req_chan.length      <= len;
      req_chan.data_byte   <= db;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Stop offering and wait for the last expected result, then let the pipe drain
   task automatic settle();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(input ncs_reg_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_chan.valid     <= 1'b1;
      csr_chan.reg_index <= idx;
      csr_chan.wdata     <= value;
      do @(posedge clock); while (!csr_chan.ready);
   endtask

   task automatic write_regs(input logic [CSR_DATA_W-1:0] log2_val, ppb_val, nblk_val);
      csr_put(REG_PAGE_LOG2, log2_val);
      csr_put(REG_PAGES_PER_BLOCK, ppb_val);
      csr_put(REG_BLOCK_COUNT, nblk_val);
      csr_chan.valid <= 1'b0;
      geo_log2   = log2_val;
      geo_ppb    = ppb_val;
      geo_blocks = nblk_val;
   endtask

   // Offsets biased toward the area boundaries of a page
   function automatic logic [OFF_W-1:0] pick_offset(input longint unsigned main_sz, page_sz);
      longint unsigned page;
      longint unsigned col;
      page = $urandom_range(0, OFF_MAX / page_sz);
      if ($urandom_range(0, 3) == 0)
         page = $urandom_range(0, 3);
      case ($urandom_range(0, 4))
         0: col = $urandom_range(0, page_sz - 1);
         1: col = $urandom_range(HALF_PAGE - 4, HALF_PAGE + 4);
         2: col = $urandom_range(main_sz - 2, page_sz - 1);
         3: col = ($urandom_range(0, 1) == 1) ? 0 : page_sz - 1;
         default: return OFF_W'($urandom);
      endcase
      return OFF_W'(page * page_sz + col);
   endfunction

   task automatic random_ops(input int target);
      longint unsigned   main_sz, page_sz, blk_sz, nblk, off;
      int                sent;
      int                kind;
      int                beats;
      logic [BYTE_W-1:0] status;
      logic [CMD_W-1:0]  noise_cmd;
      sent    = 0;
      main_sz = 1 << ((geo_log2 < 8) ? 8 : ((geo_log2 > 9) ? 9 : geo_log2));
      page_sz = main_sz + main_sz / 32;
      blk_sz  = page_sz * ((geo_ppb == 0) ? 1 : ((geo_ppb > 64) ? 64 : geo_ppb));
      nblk    = (geo_blocks == 0) ? 1 : ((geo_blocks > 4096) ? 4096 : geo_blocks);
      while (sent < target) begin
         kind = $urandom_range(0, 99);
         if (kind < 15) begin
            // mostly block-aligned, sometimes one past the end or misaligned
            off = blk_sz * $urandom_range(0, nblk);
            if ($urandom_range(0, 3) == 0)
               off += $urandom_range(1, blk_sz - 1);
            offer_request(CMD_ERASE, OFF_W'(off), LEN_W'($urandom), BYTE_W'($urandom));
            sent++;
         end else if (kind < 50) begin
            // program sequence: begin, data bytes, end, status poll
            beats = $urandom_range(0, 8);
            offer_request(CMD_PROG_BEGIN, pick_offset(main_sz, page_sz), LEN_W'($urandom),
                          BYTE_W'($urandom));
            repeat (beats)
               offer_request(CMD_PROG_DATA, OFF_W'($urandom), LEN_W'($urandom),
                             BYTE_W'($urandom));
            offer_request(CMD_PROG_END, OFF_W'($urandom), LEN_W'($urandom), BYTE_W'($urandom));
            status = BYTE_W'($urandom);
            status[STATUS_READY_BIT] = ($urandom_range(0, 3) != 0);
            offer_request(CMD_STATUS, OFF_W'($urandom), LEN_W'($urandom), status);
            sent += beats + 3;
         end else if (kind < 75) begin
            offer_request(CMD_READ_BEGIN, pick_offset(main_sz, page_sz),
                          ($urandom_range(0, 1) == 1) ? LEN_W'($urandom_range(0, 20))
                                                      : LEN_W'($urandom),
                          BYTE_W'($urandom));
            sent++;
         end else if (kind < 90) begin
            offer_request(CMD_STATUS, OFF_W'($urandom), LEN_W'($urandom), BYTE_W'($urandom));
            sent++;
         end else if (kind < 95) begin
            offer_request(CMD_PROG_DATA, OFF_W'($urandom), LEN_W'($urandom),
                          BYTE_W'($urandom));
            sent++;
         end else begin
            // noise: any code, any fields
            noise_cmd = CMD_W'($urandom);
            offer_request(noise_cmd, OFF_W'($urandom), LEN_W'($urandom), BYTE_W'($urandom));
            if (noise_cmd <= CMD_STATUS)
               sent++;
         end
      end
   endtask

   task automatic directed_items();
      // erase: first block, last block, one past the end, misaligned, top offset
      offer_request(CMD_ERASE, '0, '0, '0);
      offer_request(CMD_ERASE, OFF_W'(DEF_BLOCK_BYTES * (DEF_BLOCKS - 1)), '0, '0);
      offer_request(CMD_ERASE, OFF_W'(DEF_BLOCK_BYTES * DEF_BLOCKS), '0, '0);
      offer_request(CMD_ERASE, OFF_W'(1), '0, '0);
      offer_request(CMD_ERASE, OFF_MAX, LEN_MAX, '1);
      // program begin in each area, and a page number wider than 16 bits
      offer_request(CMD_PROG_BEGIN, '0, '0, '0);
      offer_request(CMD_PROG_BEGIN, OFF_W'(300), '0, '0);
      offer_request(CMD_PROG_BEGIN, OFF_W'(515), '0, '0);
      offer_request(CMD_PROG_BEGIN, OFF_MAX, LEN_MAX, '1);
      offer_request(CMD_PROG_DATA, '0, '0, 8'h00);
      offer_request(CMD_PROG_DATA, OFF_MAX, LEN_MAX, 8'hff);
      offer_request(CMD_PROG_END, '0, '0, '0);
      // read begin: plain, second half, spare reads that do and don't back up
      offer_request(CMD_READ_BEGIN, OFF_W'(10), '0, '0);
      offer_request(CMD_READ_BEGIN, OFF_W'(528 + 256), LEN_W'(4), '0);
      offer_request(CMD_READ_BEGIN, OFF_W'(520), LEN_W'(16), '0);
      offer_request(CMD_READ_BEGIN, OFF_W'(527), LEN_W'(1), '0);
      offer_request(CMD_READ_BEGIN, OFF_W'(527), LEN_W'(2), '0);
      offer_request(CMD_READ_BEGIN, OFF_MAX, LEN_MAX, '1);
      // status: ready, ready with fail, busy with fail bit, all ones, all zeros
      offer_request(CMD_STATUS, '0, '0, 8'h40);
      offer_request(CMD_STATUS, '0, '0, 8'h41);
      offer_request(CMD_STATUS, '0, '0, 8'h01);
      offer_request(CMD_STATUS, '0, '0, 8'hff);
      offer_request(CMD_STATUS, '0, '0, 8'h00);
      // unused codes
      offer_request(CMD_SPARE_6, OFF_W'($urandom), LEN_W'($urandom), BYTE_W'($urandom));
      offer_request(CMD_SPARE_7, OFF_W'($urandom), LEN_W'($urandom), BYTE_W'($urandom));
   endtask

   task automatic run_phase(input logic [CSR_DATA_W-1:0] log2_val, ppb_val, nblk_val,
                            input bit squeeze);
      write_regs(log2_val, ppb_val, nblk_val);
      if (squeeze) begin
         // result side holds off while data bytes keep coming: the pipe fills, input stalls
         hold_requests <= hold_requests + 1;
         burst_left = SQUEEZE_ITEMS;
         repeat (SQUEEZE_ITEMS)
            offer_request(CMD_PROG_DATA, OFF_W'($urandom), LEN_W'($urandom),
                          BYTE_W'($urandom));
      end
      random_ops(RANDOM_PER_PHASE);
      settle();
   endtask

   initial begin : stimulus
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.cmd         <= '0;
      req_chan.byte_offset <= '0;
      req_chan.length      <= '0;
      req_chan.data_byte   <= '0;
      csr_chan.valid       <= 1'b0;
      csr_chan.reg_index   <= REG_PAGE_LOG2;
      csr_chan.wdata       <= '0;
      burst_left = 0;
      geo_log2   = 13'd9;
      geo_ppb    = 13'd16;
      geo_blocks = 13'd1024;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      directed_items();
      random_ops(RANDOM_PER_PHASE);
      settle();
      run_phase(13'd8, 13'd1, 13'd1, 1'b0);
      run_phase(13'd15, 13'd64, 13'd4096, 1'b1);
      run_phase(13'd0, 13'd127, 13'd8191, 1'b0);
      run_phase(13'd9, 13'd0, 13'd0, 1'b0);
      run_phase(CSR_DATA_W'($urandom_range(0, 15)), CSR_DATA_W'($urandom_range(0, 127)),
                CSR_DATA_W'($urandom), 1'b0);

      if (errors == 0 && pending == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
